[sv/ppfq_pkg.sv]
// Shared constants, types and helpers of the physical page free queue.
package ppfq_pkg;

    localparam int FREE_PAGES = 4096;
    localparam int ADDR_BITS  = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PN_BITS    = ADDR_BITS - PAGE_SHIFT;
    localparam int IDX_BITS   = $clog2(FREE_PAGES);
    localparam int CNT_BITS   = $clog2(FREE_PAGES + 1);
    localparam int CMD_BITS   = 2;
    localparam int STAT_BITS  = 2;
    localparam int DQ_DEPTH   = 2;
    localparam int DQ_IDX     = $clog2(DQ_DEPTH);

    localparam logic [ADDR_BITS-1:0] LOW_LIMIT  = ADDR_BITS'(64'h1000);
    localparam logic [PN_BITS:0]     PAGE_LIMIT = {1'b1, {PN_BITS{1'b0}}};
    localparam logic [CNT_BITS-1:0]  PAGE_CAP   = CNT_BITS'(FREE_PAGES);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_REGION = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_REGION,
        OP_ALLOC,
        OP_FREE,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_LOAD
    } t_bstate;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        t_op                op;
        logic [PN_BITS-1:0] page;
        logic [PN_BITS-1:0] fit;
    } t_desc;

    function automatic logic [IDX_BITS-1:0] next_index(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS-1:0] res;
        if (idx == IDX_BITS'(FREE_PAGES - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_BITS'(1);
        end
        return res;
    endfunction

endpackage

[sv/ppfq_intf.sv]
// Request and response channel interfaces of the physical page free queue.
interface ppfq_req_if;
    logic                            valid;
    logic                            ready;
    logic [ppfq_pkg::CMD_BITS-1:0]   cmd;
    logic                            region_usable;
    logic [ppfq_pkg::ADDR_BITS-1:0]  region_base;
    logic [ppfq_pkg::ADDR_BITS-1:0]  region_length;
    logic [ppfq_pkg::ADDR_BITS-1:0]  free_addr;

    modport source (output valid, cmd, region_usable, region_base, region_length, free_addr,
                    input ready);
    modport sink   (input valid, cmd, region_usable, region_base, region_length, free_addr,
                    output ready);
endinterface

interface ppfq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ppfq_pkg::STAT_BITS-1:0]  status;
    logic [ppfq_pkg::ADDR_BITS-1:0]  page_addr;
    logic [ppfq_pkg::CNT_BITS-1:0]   free_count;
    logic [ppfq_pkg::CNT_BITS-1:0]   total_count;

    modport source (output valid, status, page_addr, free_count, total_count, input ready);
    modport sink   (input valid, status, page_addr, free_count, total_count, output ready);
endinterface

[sv/ppfq_front.sv]
// Front part: decodes a request and works out the page range of a region.
module ppfq_front (
    ppfq_req_if.sink            i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output ppfq_pkg::t_desc     o_desc
);
    import ppfq_pkg::*;

    logic [PN_BITS:0]   start;
    logic [PN_BITS:0]   rem;
    logic [PN_BITS-1:0] count;
    logic [PN_BITS-1:0] fit;
    logic               base_low;

    assign o_valid     = i_req.valid;
    assign i_req.ready = i_ready;

    always_comb begin
        base_low = i_req.region_base < LOW_LIMIT;
        // round the base up to a page boundary, never below the second page
        if (base_low) begin
            start = (PN_BITS+1)'(1);
        end else begin
            start = {1'b0, i_req.region_base[ADDR_BITS-1:PAGE_SHIFT]}
                  + (PN_BITS+1)'(|i_req.region_base[PAGE_SHIFT-1:0]);
        end
        rem   = PAGE_LIMIT - start;
        count = i_req.region_length[ADDR_BITS-1:PAGE_SHIFT];
        if (!i_req.region_usable || start[PN_BITS]) begin
            fit = '0;
        end else if ({1'b0, count} < rem) begin
            fit = count;
        end else begin
            fit = rem[PN_BITS-1:0];
        end

        o_desc.page = start[PN_BITS-1:0];
        o_desc.fit  = fit;
        case (t_cmd'(i_req.cmd))
            CMD_REGION: o_desc.op = OP_REGION;
            CMD_ALLOC:  o_desc.op = OP_ALLOC;
            CMD_FREE: begin
                o_desc.op   = OP_FREE;
                o_desc.page = i_req.free_addr[ADDR_BITS-1:PAGE_SHIFT];
            end
            default:    o_desc.op = OP_NOP;
        endcase
    end

endmodule

[sv/ppfq_dq.sv]
// Short request queue between the front part and the back part.
module ppfq_dq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ppfq_pkg::t_desc     i_desc,
    output logic                o_valid,
    input  logic                i_ready,
    output ppfq_pkg::t_desc     o_desc
);
    import ppfq_pkg::*;

    t_desc              r_slot [DQ_DEPTH];
    logic [DQ_IDX-1:0]  r_wp;
    logic [DQ_IDX-1:0]  r_rp;
    logic [DQ_IDX:0]    r_cnt;
    logic               push;
    logic               pop;

    assign o_ready = r_cnt != (DQ_IDX+1)'(DQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_desc  = r_slot[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == DQ_IDX'(DQ_DEPTH - 1)) ? '0 : r_wp + DQ_IDX'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == DQ_IDX'(DQ_DEPTH - 1)) ? '0 : r_rp + DQ_IDX'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (DQ_IDX+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (DQ_IDX+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_desc;
        end
    end

endmodule

[sv/ppfq_back.sv]
// Back part: page store, head and tail pointers, counts and the response register.
module ppfq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ppfq_pkg::t_desc     i_desc,
    ppfq_rsp_if.source          o_rsp
);
    import ppfq_pkg::*;

    logic [PN_BITS-1:0]  r_store [FREE_PAGES];
    logic [PN_BITS-1:0]  r_rd_data;

    t_bstate             r_state,  n_state;
    logic [IDX_BITS-1:0] r_head,   n_head;
    logic [IDX_BITS-1:0] r_tail,   n_tail;
    logic [CNT_BITS-1:0] r_avail,  n_avail;
    logic [CNT_BITS-1:0] r_loaded, n_loaded;
    logic [CNT_BITS-1:0] r_left,   n_left;
    logic [PN_BITS-1:0]  r_page,   n_page;
    logic [STAT_BITS-1:0] r_ld_stat, n_ld_stat;
    logic                r_ovalid, n_ovalid;
    logic [STAT_BITS-1:0] r_status, n_status;
    logic [ADDR_BITS-1:0] r_paddr, n_paddr;
    logic [CNT_BITS-1:0] r_fcnt,   n_fcnt;
    logic [CNT_BITS-1:0] r_tcnt,   n_tcnt;

    logic                out_free;
    logic                we;
    logic [PN_BITS-1:0]  wdata;
    logic [CNT_BITS-1:0] room;
    logic [CNT_BITS-1:0] take;
    logic [CNT_BITS:0]   lsum;

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_status;
    assign o_rsp.page_addr   = r_paddr;
    assign o_rsp.free_count  = r_fcnt;
    assign o_rsp.total_count = r_tcnt;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_avail   = r_avail;
        n_loaded  = r_loaded;
        n_left    = r_left;
        n_page    = r_page;
        n_ld_stat = r_ld_stat;
        n_status  = r_status;
        n_paddr   = r_paddr;
        n_fcnt    = r_fcnt;
        n_tcnt    = r_tcnt;
        we        = 1'b0;
        wdata     = r_page;
        o_ready   = 1'b0;
        out_free  = !r_ovalid || o_rsp.ready;
        n_ovalid  = r_ovalid && !o_rsp.ready;

        room = PAGE_CAP - r_avail;
        if (i_desc.fit < PN_BITS'(room)) begin
            take = i_desc.fit[CNT_BITS-1:0];
        end else begin
            take = room;
        end
        lsum = {1'b0, r_loaded} + {1'b0, take};

        case (r_state)
            BS_IDLE: begin
                if (i_valid && out_free) begin
                    o_ready = 1'b1;
                    case (i_desc.op)
                        OP_REGION: begin
                            n_ld_stat = (i_desc.fit > PN_BITS'(room)) ? ST_FULL : ST_OK;
                            n_loaded  = (lsum >= (CNT_BITS+1)'(FREE_PAGES)) ? PAGE_CAP
                                                                            : lsum[CNT_BITS-1:0];
                            n_left    = take;
                            n_page    = i_desc.page;
                            if (take == '0) begin
                                n_ovalid = 1'b1;
                                n_status = n_ld_stat;
                                n_paddr  = '0;
                                n_fcnt   = r_avail;
                                n_tcnt   = n_loaded;
                            end else begin
                                n_state = BS_LOAD;
                            end
                        end
                        OP_ALLOC: begin
                            if (r_avail == '0) begin
                                n_ovalid = 1'b1;
                                n_status = ST_EMPTY;
                                n_paddr  = '0;
                                n_fcnt   = r_avail;
                                n_tcnt   = r_loaded;
                            end else begin
                                // wait in BS_READ for the registered store read at the head
                                n_state = BS_READ;
                            end
                        end
                        OP_FREE: begin
                            n_ovalid = 1'b1;
                            n_paddr  = '0;
                            n_tcnt   = r_loaded;
                            if (r_avail == PAGE_CAP) begin
                                n_status = ST_FULL;
                                n_fcnt   = r_avail;
                            end else begin
                                we       = 1'b1;
                                wdata    = i_desc.page;
                                n_tail   = next_index(r_tail);
                                n_avail  = r_avail + CNT_BITS'(1);
                                n_status = ST_OK;
                                n_fcnt   = n_avail;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_status = ST_OK;
                            n_paddr  = '0;
                            n_fcnt   = r_avail;
                            n_tcnt   = r_loaded;
                        end
                    endcase
                end
            end
            BS_READ: begin
                n_head   = next_index(r_head);
                n_avail  = r_avail - CNT_BITS'(1);
                n_ovalid = 1'b1;
                n_status = ST_OK;
                n_paddr  = {r_rd_data, {PAGE_SHIFT{1'b0}}};
                n_fcnt   = n_avail;
                n_tcnt   = r_loaded;
                n_state  = BS_IDLE;
            end
            BS_LOAD: begin
                // store one page of the region per cycle
                we      = 1'b1;
                wdata   = r_page;
                n_tail  = next_index(r_tail);
                n_avail = r_avail + CNT_BITS'(1);
                n_page  = r_page + PN_BITS'(1);
                n_left  = r_left - CNT_BITS'(1);
                if (r_left == CNT_BITS'(1)) begin
                    n_ovalid = 1'b1;
                    n_status = r_ld_stat;
                    n_paddr  = '0;
                    n_fcnt   = n_avail;
                    n_tcnt   = r_loaded;
                    n_state  = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_avail  <= '0;
            r_loaded <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_avail  <= n_avail;
            r_loaded <= n_loaded;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_page    <= n_page;
        r_ld_stat <= n_ld_stat;
        r_status  <= n_status;
        r_paddr   <= n_paddr;
        r_fcnt    <= n_fcnt;
        r_tcnt    <= n_tcnt;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[r_tail] <= wdata;
        end
        r_rd_data <= r_store[r_head];
    end

endmodule

[sv/physical_page_free_queue.sv]
// Top level of the physical page free queue.
//
//  channel  direction  handshake      payload
//  i_req    in         valid / ready  cmd, region_usable, region_base, region_length, free_addr
//  o_rsp    out        valid / ready  status, page_addr, free_count, total_count
//
// A request passes the front decode into a two-entry queue in the cycle it is taken.
// The back part answers free, unknown or empty-queue allocate requests straight from idle,
// an allocate that returns a page after a registered read of the page store, and a region
// that stores pages with one store write per cycle; one response per request, in order.
// Synchronous active-low reset empties the queue and zeroes pointers and counts.
// A held response stalls the back part; a full queue stalls i_req.
module physical_page_free_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppfq_req_if.sink    i_req,
    ppfq_rsp_if.source  o_rsp
);
    import ppfq_pkg::*;

    logic  fe_valid;
    logic  fe_ready;
    t_desc fe_desc;
    logic  be_valid;
    logic  be_ready;
    t_desc be_desc;

    ppfq_front u_front (
        .i_req   (i_req),
        .o_valid (fe_valid),
        .i_ready (fe_ready),
        .o_desc  (fe_desc)
    );

    ppfq_dq u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .i_desc  (fe_desc),
        .o_valid (be_valid),
        .i_ready (be_ready),
        .o_desc  (be_desc)
    );

    ppfq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (be_valid),
        .o_ready (be_ready),
        .i_desc  (be_desc),
        .o_rsp   (o_rsp)
    );

endmodule

[tb/physical_page_free_queue_tb.sv]
// Self-checking testbench of the physical page free queue.
`timescale 1ns / 1ps

module physical_page_free_queue_tb;
    import ppfq_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam logic [63:0] PAGE_SPAN    = 64'd1 << PN_BITS;
    localparam logic [63:0] PAGE_MASK    = 64'hfff;

    typedef struct packed {
        t_cmd                 cmd;
        logic                 region_usable;
        logic [ADDR_BITS-1:0] region_base;
        logic [ADDR_BITS-1:0] region_length;
        logic [ADDR_BITS-1:0] free_addr;
    } t_page_request;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] page_addr;
        logic [CNT_BITS-1:0]  free_count;
        logic [CNT_BITS-1:0]  total_count;
    } t_page_result;

    // Mirror of the page queue; every request yields exactly one response.
    class page_queue_scoreboard;
        logic [PN_BITS-1:0] page_store [FREE_PAGES];
        int unsigned        head_idx;
        int unsigned        tail_idx;
        int unsigned        avail_pages;
        int unsigned        loaded_pages;
        t_page_result       pending_results [$];
        int unsigned        errors;
        int unsigned        n_region, n_alloc, n_free, n_other;
        int unsigned        n_empty, n_full, pages_stored;

        function void store_page(input logic [PN_BITS-1:0] page);
            page_store[tail_idx] = page;
            tail_idx             = (tail_idx + 1) % FREE_PAGES;
            avail_pages++;
        endfunction

        function void note_request(input t_page_request req);
            t_page_result res;
            logic [63:0]  base;
            logic [63:0]  count;
            logic [63:0]  start;
            logic [63:0]  fit;
            logic [63:0]  room;
            logic [63:0]  take;
            logic [63:0]  k;
            res.status      = ST_OK;
            res.page_addr   = '0;
            case (req.cmd)
                CMD_REGION: begin
                    n_region++;
                    if (req.region_usable) begin
                        base  = {16'b0, req.region_base};
                        count = {16'b0, req.region_length} >> PAGE_SHIFT;
                        // raise to the second page, then round up to a page boundary
                        if (base < {16'b0, LOW_LIMIT}) begin
                            base = {16'b0, LOW_LIMIT};
                        end
                        start = (base + PAGE_MASK) >> PAGE_SHIFT;
                        if (start >= PAGE_SPAN) begin
                            fit = 0;
                        end else begin
                            fit = (count < PAGE_SPAN - start) ? count : PAGE_SPAN - start;
                        end
                        room = 64'(FREE_PAGES - avail_pages);
                        take = (fit < room) ? fit : room;
                        if (fit > room) begin
                            res.status = ST_FULL;
                        end
                        for (k = 0; k < take; k++) begin
                            store_page(PN_BITS'(start + k));
                        end
                        pages_stored += int'(take);
                        if (64'(loaded_pages) + take >= 64'(FREE_PAGES)) begin
                            loaded_pages = FREE_PAGES;
                        end else begin
                            loaded_pages += int'(take);
                        end
                    end
                end
                CMD_ALLOC: begin
                    n_alloc++;
                    if (avail_pages == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.page_addr = {page_store[head_idx], {PAGE_SHIFT{1'b0}}};
                        head_idx      = (head_idx + 1) % FREE_PAGES;
                        avail_pages--;
                    end
                end
                CMD_FREE: begin
                    n_free++;
                    if (avail_pages >= FREE_PAGES) begin
                        res.status = ST_FULL;
                    end else begin
                        store_page(req.free_addr[ADDR_BITS-1:PAGE_SHIFT]);
                    end
                end
                default: begin
                    n_other++;
                end
            endcase
            if (res.status == ST_EMPTY) n_empty++;
            if (res.status == ST_FULL) n_full++;
            res.free_count  = CNT_BITS'(avail_pages);
            res.total_count = CNT_BITS'(loaded_pages);
            pending_results.push_back(res);
        endfunction

        function void check_response(input t_page_result got);
            t_page_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response: status %0d page_addr %h", $time,
                         got.status, got.page_addr);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                         exp.status, got.status);
                errors++;
            end
            if (got.page_addr !== exp.page_addr) begin
                $display("%0t: page_addr mismatch: expected %h, actual %h", $time,
                         exp.page_addr, got.page_addr);
                errors++;
            end
            if (got.free_count !== exp.free_count) begin
                $display("%0t: free_count mismatch: expected %0d, actual %0d", $time,
                         exp.free_count, got.free_count);
                errors++;
            end
            if (got.total_count !== exp.total_count) begin
                $display("%0t: total_count mismatch: expected %0d, actual %0d", $time,
                         exp.total_count, got.total_count);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned idle_pct  = 21;
    int unsigned stall_pct = 21;
    int unsigned cycle_count = 0;

    page_queue_scoreboard sb = new();

    ppfq_req_if req_ch();
    ppfq_rsp_if rsp_ch();

    physical_page_free_queue DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("physical_page_free_queue_tb failed");
            $finish;
        end
    end

    // Response side: sample pre-edge values, then pick the next ready at random.
    initial begin
        t_page_result got;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got.status      = t_status'(rsp_ch.status);
                got.page_addr   = rsp_ch.page_addr;
                got.free_count  = rsp_ch.free_count;
                got.total_count = rsp_ch.total_count;
                sb.check_response(got);
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input t_page_request req);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= req.cmd;
        req_ch.region_usable <= req.region_usable;
        req_ch.region_base   <= req.region_base;
        req_ch.region_length <= req.region_length;
        req_ch.free_addr     <= req.free_addr;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic send_fields(input t_cmd cmd, input logic usable,
                               input logic [ADDR_BITS-1:0] base,
                               input logic [ADDR_BITS-1:0] length,
                               input logic [ADDR_BITS-1:0] addr);
        t_page_request req;
        req.cmd           = cmd;
        req.region_usable = usable;
        req.region_base   = base;
        req.region_length = length;
        req.free_addr     = addr;
        send_request(req);
    endtask

    function automatic logic [ADDR_BITS-1:0] random_addr();
        return ADDR_BITS'({$urandom, $urandom});
    endfunction

    // Drain phases lean on allocate; refill phases on free and region loads.
    function automatic t_page_request random_request(input bit refill);
        t_page_request req;
        int unsigned   pick;
        pick              = $urandom_range(99);
        req.region_usable = ($urandom_range(9) != 0);
        req.free_addr     = random_addr();
        req.region_base   = ($urandom_range(9) == 0) ? ADDR_BITS'($urandom_range(16'h1fff))
                                                     : random_addr();
        req.region_length = (ADDR_BITS'($urandom_range(8)) << PAGE_SHIFT)
                          | ADDR_BITS'($urandom_range(12'hfff));
        if (refill) begin
            if (pick < 25)      req.cmd = CMD_ALLOC;
            else if (pick < 65) req.cmd = CMD_FREE;
            else if (pick < 95) req.cmd = CMD_REGION;
            else                req.cmd = CMD_NONE;
            if (req.cmd == CMD_REGION && $urandom_range(19) == 0) begin
                req.region_length = random_addr();
            end
        end else begin
            if (pick < 60)      req.cmd = CMD_ALLOC;
            else if (pick < 75) req.cmd = CMD_FREE;
            else if (pick < 95) req.cmd = CMD_REGION;
            else                req.cmd = CMD_NONE;
        end
        return req;
    endfunction

    initial begin
        int n;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_NONE;
        req_ch.region_usable <= 1'b0;
        req_ch.region_base   <= '0;
        req_ch.region_length <= '0;
        req_ch.free_addr     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, unknown command, unusable region, base rounding
        send_fields(CMD_ALLOC, 1'b0, '0, '0, '0);
        send_fields(CMD_NONE, 1'b1, '0, '1, '1);
        send_fields(CMD_REGION, 1'b0, 48'h5000, '1, '0);
        send_fields(CMD_REGION, 1'b1, 48'h0, 48'h3fff, '0);
        send_fields(CMD_REGION, 1'b1, 48'h1001, 48'h2fff, '0);
        // clip at the top of the address space
        send_fields(CMD_REGION, 1'b1, 48'hffff_ffff_f000, 48'h4000, '0);
        send_fields(CMD_REGION, 1'b1, 48'hffff_ffff_f001, 48'h4000, '0);
        send_fields(CMD_REGION, 1'b1, 48'h8000, 48'h0, '0);
        send_fields(CMD_REGION, 1'b1, 48'h8000, 48'hfff, '0);
        // unaligned and extreme free addresses
        send_fields(CMD_FREE, 1'b0, '0, '0, 48'hffff_ffff_ffff);
        send_fields(CMD_FREE, 1'b0, '0, '0, 48'h0);
        for (n = 0; n < 9; n++) begin
            send_fields(CMD_ALLOC, 1'b0, '0, '0, '0);
        end
        // fill the store to capacity, then push against it
        send_fields(CMD_REGION, 1'b1, 48'h10_0000, '1, '0);
        send_fields(CMD_FREE, 1'b0, '0, '0, 48'h7_0000);
        send_fields(CMD_REGION, 1'b1, 48'h2000, 48'h5000, '0);
        send_fields(CMD_ALLOC, 1'b0, '0, '0, '0);
        send_fields(CMD_FREE, 1'b0, '0, '0, 48'habc_def0_1234);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else if (n == 700) begin
                idle_pct  = 21;
                stall_pct = 21;
            end
            send_request(random_request((n / 200) % 2 == 1));
        end
        req_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d region loads (%0d pages stored), %0d allocates, %0d frees, %0d other",
                 sb.n_region, sb.pages_stored, sb.n_alloc, sb.n_free, sb.n_other);
        $display("saw %0d empty-queue and %0d store-full responses", sb.n_empty, sb.n_full);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("physical_page_free_queue_tb passed");
        end else begin
            $display("physical_page_free_queue_tb failed");
        end
        $finish;
    end

endmodule
